// ----- sv/bfrc_pkg.sv -----
package bfrc_pkg;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CKA     = 4'd7,
    PH_CKB_OK  = 4'd8,
    PH_CKB_BAD = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PAYLOAD  = 3'd1,
    EV_ACCEPT   = 3'd2,
    EV_CLASS    = 3'd3,
    EV_ID       = 3'd4,
    EV_LENGTH   = 3'd5,
    EV_CHECKSUM = 3'd6,
    EV_TIMEOUT  = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    CMD_ARM    = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_SYNC_FIRST      = 3'd0,
    CFG_SYNC_SECOND     = 3'd1,
    CFG_EXPECTED_CLASS  = 3'd2,
    CFG_EXPECTED_ID     = 3'd3,
    CFG_EXPECTED_LENGTH = 3'd4,
    CFG_TIMEOUT_TICKS   = 3'd5
  } cfg_index_t;

  localparam logic [7:0]  WILDCARD       = 8'hFF;
  localparam logic [15:0] TICK_MAX       = 16'hFFFF;
  localparam logic [7:0]  SYNC_FIRST_RST = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h62;
  localparam logic [15:0] TIMEOUT_RST    = 16'd100;

endpackage

// ----- sv/bfrc_if.sv -----
interface bfrc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface bfrc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic        waiting;

  modport source (
    output valid, output event_res, output payload_byte, output payload_index,
    output waiting, input ready
  );
  modport sink (
    input valid, input event_res, input payload_byte, input payload_index,
    input waiting, output ready
  );
endinterface

// ----- sv/binary_frame_receive_checker.sv -----
// Receive checker for sync-prefixed binary frames with an 8-bit Fletcher check.
// The input channel carries one command per transaction: arm a wait, one
// received byte, or one polling tick. The result channel returns exactly one
// transaction per input transaction, in order: an event code, the payload
// byte and its index for payload events, and the waiting flag after the step.
// The configuration port writes the sync bytes, the expected class, id and
// length, and the timeout in ticks; the user writes it only while the block
// is idle, and the block itself does not enforce this. The transaction waits
// in the input register while the parse logic works on it, and its result is
// loaded into the result register when that register is free or being taken.
// Throughput is one transaction per cycle while the receiver takes results,
// set by the combinational update of the parser state and both running sums.
// When the receiver stalls, the result register holds and the input register
// fills; after that, ready on the input channel drops until the result is
// taken. Synchronous reset empties both registers, restores the register
// defaults and leaves the parser hunting for the first sync byte, not armed.
module binary_frame_receive_checker
  import bfrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  bfrc_in_if.sink      in_ch,
  bfrc_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [7:0]  sync_first_r;
  logic [7:0]  sync_second_r;
  logic [7:0]  exp_class_r;
  logic [7:0]  exp_id_r;
  logic [15:0] exp_length_r;
  logic [15:0] timeout_r;

  logic        s1_valid_r;
  cmd_t        s1_cmd_r;
  logic [7:0]  s1_byte_r;
  logic        advance;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [15:0] decl_len_r, decl_len_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic        armed_r, armed_nxt;

  logic        out_valid_r;
  event_t      ev_r, ev_nxt;
  logic [7:0]  pb_r, pb_nxt;
  logic [15:0] pi_r, pi_nxt;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic [15:0] tick_inc;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      exp_class_r   <= WILDCARD;
      exp_id_r      <= WILDCARD;
      exp_length_r  <= '0;
      timeout_r     <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_SYNC_FIRST:      sync_first_r  <= cfg_data[7:0];
        CFG_SYNC_SECOND:     sync_second_r <= cfg_data[7:0];
        CFG_EXPECTED_CLASS:  exp_class_r   <= cfg_data[7:0];
        CFG_EXPECTED_ID:     exp_id_r      <= cfg_data[7:0];
        CFG_EXPECTED_LENGTH: exp_length_r  <= cfg_data;
        CFG_TIMEOUT_TICKS:   timeout_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_cmd_r  <= cmd_t'(in_ch.cmd);
      s1_byte_r <= in_ch.data_byte;
    end
  end

  assign add_a     = sum_a_r + s1_byte_r;
  assign add_b     = sum_b_r + add_a;
  assign len_full  = {s1_byte_r, decl_len_r[7:0]};
  assign count_inc = byte_count_r + 16'd1;
  assign tick_inc  = (tick_count_r != TICK_MAX) ? tick_count_r + 16'd1 : tick_count_r;

  always_comb begin
    phase_nxt      = phase_r;
    sum_a_nxt      = sum_a_r;
    sum_b_nxt      = sum_b_r;
    decl_len_nxt   = decl_len_r;
    byte_count_nxt = byte_count_r;
    tick_count_nxt = tick_count_r;
    armed_nxt      = armed_r;
    ev_nxt         = EV_NONE;
    pb_nxt         = '0;
    pi_nxt         = '0;

    case (s1_cmd_r)
      CMD_ARM: begin
        phase_nxt      = PH_SYNC1;
        sum_a_nxt      = '0;
        sum_b_nxt      = '0;
        decl_len_nxt   = '0;
        byte_count_nxt = '0;
        tick_count_nxt = '0;
        armed_nxt      = 1'b1;
      end
      CMD_TICK: begin
        if (armed_r) begin
          tick_count_nxt = tick_inc;
          if (tick_inc >= timeout_r) begin
            phase_nxt      = PH_SYNC1;
            sum_a_nxt      = '0;
            sum_b_nxt      = '0;
            decl_len_nxt   = '0;
            byte_count_nxt = '0;
            armed_nxt      = 1'b0;
            ev_nxt         = EV_TIMEOUT;
          end
        end
      end
      CMD_BYTE: begin
        if (armed_r) begin
          case (phase_r)
            PH_SYNC1: begin
              if (s1_byte_r == sync_first_r) begin
                phase_nxt = PH_SYNC2;
              end
            end
            PH_SYNC2: begin
              if (s1_byte_r == sync_second_r) begin
                sum_a_nxt = '0;
                sum_b_nxt = '0;
                phase_nxt = PH_CLASS;
              end else if (s1_byte_r != sync_first_r) begin
                phase_nxt = PH_SYNC1;
              end
            end
            PH_CLASS: begin
              sum_a_nxt = add_a;
              sum_b_nxt = add_b;
              phase_nxt = PH_ID;
              if (exp_class_r != WILDCARD && s1_byte_r != exp_class_r) begin
                ev_nxt = EV_CLASS;
              end
            end
            PH_ID: begin
              sum_a_nxt = add_a;
              sum_b_nxt = add_b;
              phase_nxt = PH_LEN_LO;
              if (exp_id_r != WILDCARD && s1_byte_r != exp_id_r) begin
                ev_nxt = EV_ID;
              end
            end
            PH_LEN_LO: begin
              sum_a_nxt    = add_a;
              sum_b_nxt    = add_b;
              decl_len_nxt = {8'd0, s1_byte_r};
              phase_nxt    = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              sum_a_nxt      = add_a;
              sum_b_nxt      = add_b;
              decl_len_nxt   = len_full;
              byte_count_nxt = '0;
              if (len_full != exp_length_r) begin
                ev_nxt = EV_LENGTH;
              end else if (len_full == 16'd0) begin
                phase_nxt = PH_CKA;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
            PH_PAYLOAD: begin
              sum_a_nxt      = add_a;
              sum_b_nxt      = add_b;
              pb_nxt         = s1_byte_r;
              pi_nxt         = byte_count_r;
              byte_count_nxt = count_inc;
              ev_nxt         = EV_PAYLOAD;
              if (count_inc == decl_len_r) begin
                phase_nxt = PH_CKA;
              end
            end
            PH_CKA: begin
              phase_nxt = (s1_byte_r == sum_a_r) ? PH_CKB_OK : PH_CKB_BAD;
            end
            PH_CKB_OK: begin
              if (s1_byte_r == sum_b_r) begin
                ev_nxt    = EV_ACCEPT;
                armed_nxt = 1'b0;
              end else begin
                ev_nxt = EV_CHECKSUM;
              end
            end
            default: begin
              ev_nxt = EV_CHECKSUM;
            end
          endcase

          if (ev_nxt inside {EV_ACCEPT, EV_CLASS, EV_ID, EV_LENGTH, EV_CHECKSUM}) begin
            phase_nxt      = PH_SYNC1;
            sum_a_nxt      = '0;
            sum_b_nxt      = '0;
            decl_len_nxt   = '0;
            byte_count_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SYNC1;
      sum_a_r      <= '0;
      sum_b_r      <= '0;
      decl_len_r   <= '0;
      byte_count_r <= '0;
      tick_count_r <= '0;
      armed_r      <= 1'b0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      sum_a_r      <= sum_a_nxt;
      sum_b_r      <= sum_b_nxt;
      decl_len_r   <= decl_len_nxt;
      byte_count_r <= byte_count_nxt;
      tick_count_r <= tick_count_nxt;
      armed_r      <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_r <= ev_nxt;
      pb_r <= pb_nxt;
      pi_r <= pi_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_res     = ev_r;
  assign out_ch.payload_byte  = pb_r;
  assign out_ch.payload_index = pi_r;
  assign out_ch.waiting       = armed_r;

  // The parser only leaves sync hunting while a wait is open.
  a_phase_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_SYNC1) |-> armed_r)
    else $error("parser left sync hunting while not armed");

  a_accept_ends_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (ev_r == EV_ACCEPT || ev_r == EV_TIMEOUT)) |-> !armed_r)
    else $error("accept or timeout reported while still waiting");

  a_payload_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ev_r == EV_PAYLOAD) |-> armed_r)
    else $error("payload byte reported outside a wait");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !advance)
    else $error("result register overwritten while stalled");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r)
    else $error("input register dropped a transaction");

endmodule
